@@ hw/rtl/cll_pkg.sv @@
// Shared types and constants of the command line lexer.
`timescale 1ns / 1ps

package cll_pkg;

  localparam logic [2:0] MK_NONE       = 3'd0;
  localparam logic [2:0] MK_NAME_BEGIN = 3'd1;
  localparam logic [2:0] MK_ARG_BEGIN  = 3'd2;
  localparam logic [2:0] MK_QUOTE_OPEN = 3'd3;
  localparam logic [2:0] MK_NAME_END   = 3'd4;
  localparam logic [2:0] MK_ARG_END    = 3'd5;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_CHAR  = 2'd1;
  localparam logic [1:0] ERR_ARGS  = 2'd2;
  localparam logic [1:0] ERR_EMPTY = 2'd3;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_US    = 8'h5F;

  localparam int OUT_DATA_W = 24;

  typedef struct packed {
    logic is_zero;
    logic is_nl;
    logic is_blank;
    logic is_letter;
    logic is_us;
    logic is_word;
    logic is_dq;
    logic is_sq;
  } char_class_t;

  typedef struct packed {
    logic        ignored;
    logic [11:0] position;
    logic [1:0]  error_code;
    logic [3:0]  arg_count;
    logic        line_done;
    logic [2:0]  mark;
  } lex_result_t;

endpackage

@@ hw/rtl/cll_char_class.sv @@
// Character classification for the command line lexer.
`timescale 1ns / 1ps

module cll_char_class (
  input  logic [7:0]           char_code,
  output cll_pkg::char_class_t cls
);

  logic letter;
  logic digit;

  assign letter = ((char_code >= 8'h61) && (char_code <= 8'h7A)) ||
                  ((char_code >= 8'h41) && (char_code <= 8'h5A));
  assign digit  = (char_code >= 8'h30) && (char_code <= 8'h39);

  always_comb begin
    cls.is_zero   = (char_code == cll_pkg::CH_NUL);
    cls.is_nl     = (char_code == cll_pkg::CH_NL);
    cls.is_blank  = (char_code == cll_pkg::CH_NL) || (char_code == cll_pkg::CH_SPACE);
    cls.is_letter = letter;
    cls.is_us     = (char_code == cll_pkg::CH_US);
    cls.is_word   = letter || digit || (char_code == cll_pkg::CH_DASH) ||
                    (char_code == cll_pkg::CH_US);
    cls.is_dq     = (char_code == cll_pkg::CH_DQ);
    cls.is_sq     = (char_code == cll_pkg::CH_SQ);
  end

endmodule

@@ hw/rtl/cll_lex_core.sv @@
// Lexer state machine, argument counter and chunk offset.
`timescale 1ns / 1ps

module cll_lex_core #(
  parameter int MAX_ARGS    = 8,
  parameter int CHUNK_BYTES = 4096
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 chunk_last,
  input  cll_pkg::char_class_t cls,
  output cll_pkg::lex_result_t res
);

  localparam int OFF_W = $clog2(CHUNK_BYTES);

  localparam logic [2:0] ST_LEAD   = 3'd0;
  localparam logic [2:0] ST_NAME   = 3'd1;
  localparam logic [2:0] ST_GAP    = 3'd2;
  localparam logic [2:0] ST_PLAIN  = 3'd3;
  localparam logic [2:0] ST_QUOTED = 3'd4;
  localparam logic [2:0] ST_ABORT  = 3'd5;

  logic [2:0]       state_r, state_nxt;
  logic             dq_r, dq_nxt;
  logic [3:0]       args_r, args_nxt;
  logic [OFF_W-1:0] off_r, off_nxt;
  logic             have_r, have_nxt;

  logic [OFF_W:0]    off_sum;
  logic [OFF_W+11:0] pos_ext;
  logic              room;
  logic              close_q;

  assign off_sum = {1'b0, off_r} + {{OFF_W{1'b0}}, 1'b1};
  assign pos_ext = {12'd0, off_r};
  assign room    = (args_r < 4'(MAX_ARGS));
  assign close_q = dq_r ? cls.is_dq : cls.is_sq;

  always_comb begin
    state_nxt      = state_r;
    dq_nxt         = dq_r;
    args_nxt       = args_r;
    have_nxt       = have_r;
    res.mark       = cll_pkg::MK_NONE;
    res.line_done  = 1'b0;
    res.error_code = cll_pkg::ERR_NONE;
    res.ignored    = 1'b0;
    res.position   = pos_ext[11:0];

    if ((state_r > ST_QUOTED) || cls.is_zero) begin
      res.ignored = 1'b1;
      state_nxt   = ST_ABORT;
    end else begin
      unique case (state_r)
        ST_LEAD: begin
          if (cls.is_letter || cls.is_us) begin
            res.mark  = cll_pkg::MK_NAME_BEGIN;
            have_nxt  = 1'b1;
            state_nxt = ST_NAME;
          end else if (!cls.is_blank) begin
            res.error_code = cll_pkg::ERR_CHAR;
          end
        end
        ST_NAME: begin
          if (cls.is_blank) begin
            res.mark  = cll_pkg::MK_NAME_END;
            state_nxt = ST_GAP;
          end else if (!cls.is_word) begin
            res.error_code = cll_pkg::ERR_CHAR;
          end
        end
        ST_GAP: begin
          if (cls.is_word) begin
            res.mark  = cll_pkg::MK_ARG_BEGIN;
            state_nxt = ST_PLAIN;
          end else if (cls.is_dq || cls.is_sq) begin
            res.mark  = cll_pkg::MK_QUOTE_OPEN;
            dq_nxt    = cls.is_dq;
            state_nxt = ST_QUOTED;
          end else if (!cls.is_blank) begin
            res.error_code = cll_pkg::ERR_CHAR;
          end
        end
        ST_PLAIN: begin
          if (cls.is_blank) begin
            if (room) begin
              args_nxt  = args_r + 4'd1;
              res.mark  = cll_pkg::MK_ARG_END;
              state_nxt = ST_GAP;
            end else begin
              res.error_code = cll_pkg::ERR_ARGS;
            end
          end else if (!cls.is_word) begin
            res.error_code = cll_pkg::ERR_CHAR;
          end
        end
        ST_QUOTED: begin
          if (close_q) begin
            if (room) begin
              args_nxt  = args_r + 4'd1;
              res.mark  = cll_pkg::MK_ARG_END;
              state_nxt = ST_GAP;
            end else begin
              res.error_code = cll_pkg::ERR_ARGS;
            end
          end else if (cls.is_nl) begin
            res.error_code = cll_pkg::ERR_CHAR;
          end
        end
        default: begin
          state_nxt = ST_ABORT;
        end
      endcase
      if ((res.error_code == cll_pkg::ERR_NONE) && cls.is_nl) begin
        if (!have_r) begin
          res.error_code = cll_pkg::ERR_EMPTY;
        end else begin
          res.line_done = 1'b1;
        end
      end
      if (res.error_code != cll_pkg::ERR_NONE) begin
        state_nxt = ST_ABORT;
      end
    end

    res.arg_count = args_nxt;
    if (res.line_done) begin
      state_nxt = ST_LEAD;
      have_nxt  = 1'b0;
      args_nxt  = 4'd0;
    end

    off_nxt = (off_sum >= (OFF_W+1)'(CHUNK_BYTES)) ? '0 : off_sum[OFF_W-1:0];
    if (chunk_last) begin
      state_nxt = ST_LEAD;
      dq_nxt    = 1'b0;
      args_nxt  = 4'd0;
      off_nxt   = '0;
      have_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LEAD;
      dq_r    <= 1'b0;
      args_r  <= 4'd0;
      off_r   <= '0;
      have_r  <= 1'b0;
    end else if (en) begin
      state_r <= state_nxt;
      dq_r    <= dq_nxt;
      args_r  <= args_nxt;
      off_r   <= off_nxt;
      have_r  <= have_nxt;
    end
  end

  a_err_aborts: assert property (@(posedge clk) disable iff (!rst_n)
    en && (res.error_code != cll_pkg::ERR_NONE) && !chunk_last |=> state_r == ST_ABORT)
    else $error("error did not abort the chunk");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    en && chunk_last |=> (state_r == ST_LEAD) && (args_r == 4'd0) && (off_r == '0) && !have_r)
    else $error("state not cleared after the last byte of a chunk");

  a_done_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    en && res.line_done |=> (state_r == ST_LEAD) && (args_r == 4'd0) && !have_r)
    else $error("completed line did not restart the lexer");

  a_args_bound: assert property (@(posedge clk) disable iff (!rst_n)
    en |=> args_r <= 4'(MAX_ARGS))
    else $error("argument count above its limit");

endmodule

@@ hw/rtl/command_line_lexer.sv @@
// Top level of the command line lexer: input register, lexer core and result register.
// A character accepted into the input register is lexed and its result is registered for out_*.
// Throughput: one character per clock cycle while no result waits for out_tready.
// The result register lets a new character enter while a result waits for out_tready.
// Synchronous active-low reset empties both registers and returns the lexer to its begin
// state with the argument count, quote flag and chunk offset at zero.
`timescale 1ns / 1ps

module command_line_lexer #(
  parameter int MAX_ARGS    = 8,
  parameter int CHUNK_BYTES = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,  // char_code
  input  logic                           in_tlast,  // chunk_last
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // mark[2:0], line_done[3], arg_count[7:4], error_code[9:8], position[21:10],
  // ignored[22], zero padding[23]
  output logic [cll_pkg::OUT_DATA_W-1:0] out_tdata
);

  logic                 in_v_r;
  logic [7:0]           in_char_r;
  logic                 in_last_r;
  logic                 out_v_r;
  cll_pkg::lex_result_t out_res_r;
  logic                 adv;

  cll_pkg::char_class_t cls;
  cll_pkg::lex_result_t res;

  assign adv       = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || adv;

  cll_char_class u_class (
    .char_code (in_char_r),
    .cls       (cls)
  );

  cll_lex_core #(
    .MAX_ARGS    (MAX_ARGS),
    .CHUNK_BYTES (CHUNK_BYTES)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (adv),
    .chunk_last (in_last_r),
    .cls        (cls),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_v_r <= in_tvalid;
      end
      if (adv) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_char_r <= in_tdata;
      in_last_r <= in_tlast;
    end
    if (adv) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {1'b0, out_res_r};

endmodule

@@ tb/command_line_lexer_checker.sv @@
// Checker for the command line lexer: predicts each result from the accepted characters and compares.
`timescale 1ns / 1ps

module command_line_lexer_checker #(
  parameter int MAX_ARGS    = 8,
  parameter int CHUNK_BYTES = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [7:0]                     in_tdata,  // char_code
  input  logic                           in_tlast,  // chunk_last
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  // mark[2:0], line_done[3], arg_count[7:4], error_code[9:8], position[21:10],
  // ignored[22], zero padding[23]
  input  logic [cll_pkg::OUT_DATA_W-1:0] out_tdata,
  output int                             fail_count,
  output int                             pending,
  output int                             live_chars,
  output int                             results_checked,
  output int                             lines_completed,
  output int                             chunks_aborted
);

  typedef enum logic [2:0] {
    LS_BEGIN,
    LS_NAME,
    LS_GAP,
    LS_PLAIN,
    LS_QUOTED,
    LS_ABORT
  } lex_state_t;

  lex_state_t  state;
  logic        quote_dq;
  logic [3:0]  args;
  int          offset;
  logic        named;

  cll_pkg::lex_result_t pending_results[$];
  int          fails;
  int          n_live;
  int          n_checked;
  int          n_lines;
  int          n_aborts;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_letter(c) || (c >= "0" && c <= "9") || c == cll_pkg::CH_DASH ||
           c == cll_pkg::CH_US;
  endfunction

  function void clear_lexer();
    state    = LS_BEGIN;
    quote_dq = 1'b0;
    args     = '0;
    offset   = 0;
    named    = 1'b0;
  endfunction

  function cll_pkg::lex_result_t lex_char(input logic [7:0] c, input logic last);
    cll_pkg::lex_result_t r;
    logic        blank;
    logic        closing;
    r       = '0;
    closing = 1'b0;
    r.position = offset[11:0];
    blank = (c == cll_pkg::CH_SPACE) || (c == cll_pkg::CH_NL);
    if (state == LS_ABORT || c == cll_pkg::CH_NUL) begin
      r.ignored = 1'b1;
      state     = LS_ABORT;
    end else begin
      case (state)
        LS_BEGIN: begin
          if (is_letter(c) || c == cll_pkg::CH_US) begin
            r.mark = cll_pkg::MK_NAME_BEGIN;
            named  = 1'b1;
            state  = LS_NAME;
          end else if (!blank) begin
            r.error_code = cll_pkg::ERR_CHAR;
          end
        end
        LS_NAME: begin
          if (blank) begin
            r.mark = cll_pkg::MK_NAME_END;
            state  = LS_GAP;
          end else if (!is_word(c)) begin
            r.error_code = cll_pkg::ERR_CHAR;
          end
        end
        LS_GAP: begin
          if (is_word(c)) begin
            r.mark = cll_pkg::MK_ARG_BEGIN;
            state  = LS_PLAIN;
          end else if (c == cll_pkg::CH_DQ || c == cll_pkg::CH_SQ) begin
            r.mark   = cll_pkg::MK_QUOTE_OPEN;
            quote_dq = (c == cll_pkg::CH_DQ);
            state    = LS_QUOTED;
          end else if (!blank) begin
            r.error_code = cll_pkg::ERR_CHAR;
          end
        end
        LS_PLAIN: begin
          if (blank) begin
            closing = 1'b1;
          end else if (!is_word(c)) begin
            r.error_code = cll_pkg::ERR_CHAR;
          end
        end
        default: begin
          if (c == (quote_dq ? cll_pkg::CH_DQ : cll_pkg::CH_SQ)) begin
            closing = 1'b1;
          end else if (c == cll_pkg::CH_NL) begin
            r.error_code = cll_pkg::ERR_CHAR;
          end
        end
      endcase
      if (closing) begin
        if (args < MAX_ARGS) begin
          args   = args + 1'b1;
          r.mark = cll_pkg::MK_ARG_END;
          state  = LS_GAP;
        end else begin
          r.error_code = cll_pkg::ERR_ARGS;
        end
      end
      if (r.error_code == cll_pkg::ERR_NONE && c == cll_pkg::CH_NL) begin
        if (!named) begin
          r.error_code = cll_pkg::ERR_EMPTY;
        end else begin
          r.line_done = 1'b1;
        end
      end
      if (r.error_code != cll_pkg::ERR_NONE) begin
        state = LS_ABORT;
      end
    end
    r.arg_count = args;
    if (r.line_done) begin
      state = LS_BEGIN;
      named = 1'b0;
      args  = '0;
    end
    offset = (offset + 1 >= CHUNK_BYTES) ? 0 : offset + 1;
    if (last) begin
      clear_lexer();
    end
    return r;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fails++;
    end
  endtask

  initial begin
    clear_lexer();
    fails     = 0;
    n_live    = 0;
    n_checked = 0;
    n_lines   = 0;
    n_aborts  = 0;
  end

  always @(posedge clk) begin
    cll_pkg::lex_result_t got;
    cll_pkg::lex_result_t want;
    if (!rst_n) begin
      clear_lexer();
      pending_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[$bits(cll_pkg::lex_result_t)-1:0];
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_tdata);
          fails++;
        end else begin
          want = pending_results.pop_front();
          check_field("mark", want.mark, got.mark);
          check_field("line_done", want.line_done, got.line_done);
          check_field("arg_count", want.arg_count, got.arg_count);
          check_field("error_code", want.error_code, got.error_code);
          check_field("position", want.position, got.position);
          check_field("ignored", want.ignored, got.ignored);
          check_field("padding", 0,
                      out_tdata[cll_pkg::OUT_DATA_W-1:$bits(cll_pkg::lex_result_t)]);
          n_checked++;
          if (want.line_done) n_lines++;
          if (want.error_code != cll_pkg::ERR_NONE) n_aborts++;
        end
      end
      if (in_tvalid && in_tready) begin
        want = lex_char(in_tdata, in_tlast);
        if (!want.ignored) n_live++;
        pending_results.push_back(want);
      end
    end
    fail_count      <= fails;
    pending         <= pending_results.size();
    live_chars      <= n_live;
    results_checked <= n_checked;
    lines_completed <= n_lines;
    chunks_aborted  <= n_aborts;
  end

endmodule

@@ tb/tb_command_line_lexer.sv @@
// Testbench top for the command line lexer: clock, reset, character stimulus and verdict.
`timescale 1ns / 1ps

module tb_command_line_lexer;

  localparam int MAX_ARGS    = 8;
  localparam int CHUNK_BYTES = 4096;

  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  logic [7:0]                     in_tdata   = '0;
  logic                           in_tlast   = 1'b0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [cll_pkg::OUT_DATA_W-1:0] out_tdata;

  int fail_count;
  int pending;
  int live_chars;
  int results_checked;
  int lines_completed;
  int chunks_aborted;

  logic       idle_on   = 1'b1;
  logic       hold_req  = 1'b0;
  logic       hold_done = 1'b0;
  logic [7:0] text[$];
  int         n_sent    = 0;

  command_line_lexer #(
    .MAX_ARGS   (MAX_ARGS),
    .CHUNK_BYTES(CHUNK_BYTES)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  command_line_lexer_checker #(
    .MAX_ARGS   (MAX_ARGS),
    .CHUNK_BYTES(CHUNK_BYTES)
  ) i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tlast       (in_tlast),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .fail_count     (fail_count),
    .pending        (pending),
    .live_chars     (live_chars),
    .results_checked(results_checked),
    .lines_completed(lines_completed),
    .chunks_aborted (chunks_aborted)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_tready <= 1'b0;
        repeat (60) @(posedge clk);
        hold_done = 1'b1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  function automatic logic [7:0] letter_char();
    return $urandom_range(0, 1) ? 8'("a" + $urandom_range(0, 25))
                                : 8'("A" + $urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] word_char();
    case ($urandom_range(0, 3))
      0:       return letter_char();
      1:       return 8'("0" + $urandom_range(0, 9));
      2:       return cll_pkg::CH_DASH;
      default: return cll_pkg::CH_US;
    endcase
  endfunction

  task automatic send_char(input logic [7:0] c, input logic last);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n_sent++;
  endtask

  task automatic drive_string(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i], i == s.len() - 1);
    end
  endtask

  task automatic drive_text();
    foreach (text[i]) begin
      send_char(text[i], i == text.size() - 1);
    end
  endtask

  // A line: optional leading blanks, a name, up to nine arguments (one above MAX_ARGS), newline.
  task automatic add_line();
    logic [7:0] q;
    logic [7:0] ch;
    int         n_args;
    repeat ($urandom_range(0, 2)) text.push_back(cll_pkg::CH_SPACE);
    text.push_back($urandom_range(0, 5) == 0 ? cll_pkg::CH_US : letter_char());
    repeat ($urandom_range(0, 4)) text.push_back(word_char());
    n_args = $urandom_range(0, MAX_ARGS + 1);
    for (int i = 0; i < n_args; i++) begin
      repeat ($urandom_range(1, 2)) text.push_back(cll_pkg::CH_SPACE);
      if ($urandom_range(0, 2) == 0) begin
        q = $urandom_range(0, 1) ? cll_pkg::CH_DQ : cll_pkg::CH_SQ;
        text.push_back(q);
        repeat ($urandom_range(0, 4)) begin
          ch = 8'($urandom_range(1, 255));
          if (ch == cll_pkg::CH_NL || ch == q) begin
            ch = (q == cll_pkg::CH_DQ) ? cll_pkg::CH_SQ : cll_pkg::CH_DQ;
          end
          text.push_back(ch);
        end
        text.push_back(q);
      end else begin
        repeat ($urandom_range(1, 5)) text.push_back(word_char());
      end
    end
    if ($urandom_range(0, 1)) text.push_back(cll_pkg::CH_SPACE);
    text.push_back(cll_pkg::CH_NL);
  endtask

  task automatic random_chunk();
    text.delete();
    repeat ($urandom_range(1, 4)) add_line();
    if ($urandom_range(0, 9) == 0) text.insert($urandom_range(0, text.size()), cll_pkg::CH_NL);
    if ($urandom_range(0, 19) == 0) text.insert($urandom_range(0, text.size()), cll_pkg::CH_NUL);
    foreach (text[i]) begin
      if ($urandom_range(0, 199) == 0) text[i] = 8'($urandom_range(0, 255));
    end
    if ($urandom_range(0, 7) == 0) text = text[0:$urandom_range(0, text.size() - 1)];
    drive_text();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Empty line, then a name with a plain argument, then a name with a quoted argument that holds
    // the other quote and is broken by a newline, followed by an ignored tail.
    drive_string("\n");
    drive_string("Zz-_9 -a\nq \"'\nx");
    send_char(8'hFF, 1'b1);
    send_char("a", 1'b0);
    send_char(cll_pkg::CH_NUL, 1'b0);
    send_char("b", 1'b1);
    drive_string("q\n");
    drive_string("k 'a\"'\n");

    // The receiver stalls for a long stretch while characters keep coming.
    hold_req = 1'b1;
    random_chunk();
    while (!hold_done) random_chunk();

    while (n_sent < 1450) random_chunk();
    idle_on = 1'b0;
    while (n_sent < 1650) random_chunk();
    in_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Checked %0d results from %0d characters sent, %0d of them lexed.",
             results_checked, n_sent, live_chars);
    $display("Lines completed: %0d, chunks aborted by errors: %0d.",
             lines_completed, chunks_aborted);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ command_line_lexer.f @@
hw/rtl/cll_pkg.sv
hw/rtl/cll_char_class.sv
hw/rtl/cll_lex_core.sv
hw/rtl/command_line_lexer.sv
tb/command_line_lexer_checker.sv
tb/tb_command_line_lexer.sv
